// ===== rtl/sacl_pkg.sv =====
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative LRU tag store.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int ADDR_W         = 64;
  localparam int WAY_OUT_W      = 3;
  localparam int DEF_WAYS       = 8;
  localparam int DEF_SETS       = 32;
  localparam int DEF_LINE_BYTES = 64;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } sacl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic match_en;
    logic update_en;
  } sacl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic out_blocked;
  } sacl_sts_t;

endpackage

// ===== rtl/set_assoc_cache_lru_tags_top.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tags_top
// Tag store of a set-associative cache with least-recently-used replacement.
//
//   Channel  Signals                        Direction  Moves per transfer
//   input    in_valid, in_stall, address    in         one byte address
//   output   out_valid, out_stall, hit,     out        hit flag and way used
//            way_used
//
// An access has three steps: accept and set RAM read, way compare, then
// rank update with write-back and loading of the result register.
// After reset a clearing pass writes every set row while in_stall is held
// high. The next address is taken as soon as the previous one has been
// written back, even if its result is still waiting; a held result stops the
// write-back of the following access. SETS and LINE_BYTES must be powers of
// two; the block does not check this.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_tags_top
  import sacl_pkg::*;
#(
  parameter int WAYS       = DEF_WAYS,
  parameter int SETS       = DEF_SETS,
  parameter int LINE_BYTES = DEF_LINE_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ADDR_W-1:0]    address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output logic [WAY_OUT_W-1:0] way_used
);

  sacl_cmd_t cmd;
  sacl_sts_t sts;

  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sacl_dp #(
    .WAYS       (WAYS),
    .SETS       (SETS),
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .address   (address),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .way_used  (way_used)
  );

endmodule

// ===== rtl/sacl_ram.sv =====
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sacl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer of the tag store: clearing pass, accept, match and update steps.
// ----------------------------------------------------------------------------
module sacl_ctrl
  import sacl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  sacl_sts_t sts,
  output sacl_cmd_t cmd
);

  sacl_state_t state;
  sacl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.match_en = 1'b1;
        state_next   = ST_UPDATE;
      end
      ST_UPDATE: begin
        // The set is written back only once the result register can take it.
        if (!sts.out_blocked) begin
          cmd.update_en = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/sacl_dp.sv =====
// ----------------------------------------------------------------------------
// sacl_dp
// Datapath of the tag store: set RAM, way compare, victim choice, rank update.
// ----------------------------------------------------------------------------
module sacl_dp
  import sacl_pkg::*;
#(
  parameter int WAYS       = DEF_WAYS,
  parameter int SETS       = DEF_SETS,
  parameter int LINE_BYTES = DEF_LINE_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sacl_cmd_t            cmd,
  output sacl_sts_t            sts,
  input  logic [ADDR_W-1:0]    address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output logic [WAY_OUT_W-1:0] way_used
);

  localparam int OFF_BITS = $clog2(LINE_BYTES);
  localparam int SET_BITS = $clog2(SETS);
  localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_W    = ADDR_W - OFF_BITS - SET_BITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W   = WAY_W;
  localparam int VLD_LO   = WAYS * TAG_W;
  localparam int RANK_LO  = WAYS * (TAG_W + 1);
  localparam int ROW_W    = WAYS * (TAG_W + 1 + RANK_W);

  localparam logic [RANK_W-1:0] RANK_OLDEST = RANK_W'(WAYS - 1);
  localparam logic [SET_W-1:0]  SET_LAST    = SET_W'(SETS - 1);

  // Address split.
  logic [SET_W-1:0] set_in;
  logic [TAG_W-1:0] tag_in;

  assign set_in = SET_W'((address >> OFF_BITS) % SETS);
  assign tag_in = TAG_W'(address >> (OFF_BITS + SET_BITS));

  // Set RAM: one row holds the tags, valid bits and age ranks of all ways.
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (set_in),
    .rdata (ram_rdata)
  );

  // Clearing pass after reset.
  logic [SET_W-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_wr && clr_cnt != SET_LAST) begin
      clr_cnt <= clr_cnt + SET_W'(1);
    end
  end

  // Accepted item.
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      set_q <= set_in;
      tag_q <= tag_in;
    end
  end

  // Match step: compare all ways of the row and pick the way to use.
  logic [TAG_W-1:0]  rd_tag   [WAYS];
  logic [WAYS-1:0]   rd_valid;
  logic [RANK_W-1:0] rd_rank  [WAYS];
  logic [WAYS-1:0]   hit_vec;
  logic              any_hit;
  logic [WAY_W-1:0]  hit_way;
  logic              have_inv;
  logic [WAY_W-1:0]  inv_way;
  logic [WAY_W-1:0]  lru_way;
  logic [WAY_W-1:0]  chosen;

  always_comb begin
    hit_way  = '0;
    inv_way  = '0;
    lru_way  = '0;
    have_inv = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      rd_tag[w]   = ram_rdata[w*TAG_W +: TAG_W];
      rd_valid[w] = ram_rdata[VLD_LO + w];
      rd_rank[w]  = ram_rdata[RANK_LO + w*RANK_W +: RANK_W];
      hit_vec[w]  = rd_valid[w] && (rd_tag[w] == tag_q);
    end
    any_hit = |hit_vec;
    // Scanning downwards leaves the lowest-numbered candidate in each case.
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!rd_valid[w]) begin
        inv_way  = WAY_W'(w);
        have_inv = 1'b1;
      end
      if (rd_rank[w] == RANK_OLDEST) begin
        lru_way = WAY_W'(w);
      end
    end
    if (any_hit) begin
      chosen = hit_way;
    end else if (have_inv) begin
      chosen = inv_way;
    end else begin
      chosen = lru_way;
    end
  end

  logic [TAG_W-1:0]  m_tag   [WAYS];
  logic [WAYS-1:0]   m_valid;
  logic [RANK_W-1:0] m_rank  [WAYS];
  logic [WAY_W-1:0]  chosen_q;
  logic              hit_q;
  logic              was_valid_q;

  always_ff @(posedge clk) begin
    if (cmd.match_en) begin
      m_tag       <= rd_tag;
      m_valid     <= rd_valid;
      m_rank      <= rd_rank;
      chosen_q    <= chosen;
      hit_q       <= any_hit;
      was_valid_q <= any_hit || !have_inv;
    end
  end

  // Update step: age the younger ways and make the chosen way most recent.
  logic [RANK_W:0]   old_rank;
  logic [ROW_W-1:0]  new_row;

  always_comb begin
    old_rank = was_valid_q ? {1'b0, m_rank[chosen_q]} : (RANK_W + 1)'(WAYS);
    new_row  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == chosen_q) begin
        new_row[w*TAG_W +: TAG_W]              = tag_q;
        new_row[VLD_LO + w]                    = 1'b1;
        new_row[RANK_LO + w*RANK_W +: RANK_W]  = '0;
      end else begin
        new_row[w*TAG_W +: TAG_W]              = m_tag[w];
        new_row[VLD_LO + w]                    = m_valid[w];
        if (m_valid[w] && ({1'b0, m_rank[w]} < old_rank) && (m_rank[w] < RANK_OLDEST)) begin
          new_row[RANK_LO + w*RANK_W +: RANK_W] = m_rank[w] + RANK_W'(1);
        end else begin
          new_row[RANK_LO + w*RANK_W +: RANK_W] = m_rank[w];
        end
      end
    end
  end

  assign ram_we    = cmd.clear_wr || cmd.update_en;
  assign ram_waddr = cmd.clear_wr ? clr_cnt : set_q;
  assign ram_wdata = cmd.clear_wr ? '0 : new_row;

  // Result register.
  logic [WAY_W+WAY_OUT_W-1:0] chosen_ext;

  assign chosen_ext = {{WAY_OUT_W{1'b0}}, chosen_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update_en) begin
      hit      <= hit_q;
      way_used <= chosen_ext[WAY_OUT_W-1:0];
    end
  end

  assign sts.clr_last    = (clr_cnt == SET_LAST);
  assign sts.out_blocked = out_valid && out_stall;

endmodule

// ===== verif/lru_tag_checker.sv =====
// ----------------------------------------------------------------------------
// lru_tag_checker
// Watches both channels of the LRU tag store. It keeps its own copy of the
// tags, valid bits and age ranks, works out the hit flag and way of every
// accepted address, and compares each returned result with the oldest one
// still outstanding.
// ----------------------------------------------------------------------------
module lru_tag_checker
  import sacl_pkg::*;
#(
  parameter int WAYS       = DEF_WAYS,
  parameter int SETS       = DEF_SETS,
  parameter int LINE_BYTES = DEF_LINE_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [ADDR_W-1:0]    address,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 hit,
  input  logic [WAY_OUT_W-1:0] way_used,
  output int                   fail_count,
  output int                   pending,
  output int                   hit_count,
  output int                   miss_count,
  output int                   evict_count
);

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
  } lookup_res_t;

  logic [ADDR_W-1:0] tag_mem   [SETS][WAYS];
  logic              valid_mem [SETS][WAYS];
  int unsigned       age_rank  [SETS][WAYS];
  lookup_res_t       lookup_q[$];
  lookup_res_t       oldest;

  // Makes a way the most recent one of its set. A way that was invalid
  // counts as older than all others, so every valid way ages.
  function automatic void touch_way(int unsigned s, int unsigned way, bit was_valid);
    int unsigned old_rank;
    old_rank = was_valid ? age_rank[s][way] : WAYS;
    for (int w = 0; w < WAYS; w++) begin
      if (w != way && valid_mem[s][w] && age_rank[s][w] < old_rank &&
          age_rank[s][w] < WAYS - 1)
        age_rank[s][w]++;
    end
    age_rank[s][way] = 0;
  endfunction

  function automatic lookup_res_t lookup_and_fill(logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] line;
    logic [ADDR_W-1:0] tag;
    int unsigned       s;
    int unsigned       chosen;
    int unsigned       best;
    bit                found;
    bit                have_invalid;
    lookup_res_t       r;
    line         = a / LINE_BYTES;
    s            = 32'(line % SETS);
    tag          = line / SETS;
    chosen       = 0;
    found        = 1'b0;
    have_invalid = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && valid_mem[s][w] && tag_mem[s][w] == tag) begin
        chosen = w;
        found  = 1'b1;
      end
    end
    if (found) begin
      touch_way(s, chosen, 1'b1);
      hit_count++;
    end else begin
      for (int w = 0; w < WAYS; w++) begin
        if (!have_invalid && !valid_mem[s][w]) begin
          chosen       = w;
          have_invalid = 1'b1;
        end
      end
      // With the set full, the oldest way goes; ties fall to the lowest way.
      if (!have_invalid) begin
        best   = 0;
        chosen = 0;
        for (int w = 0; w < WAYS; w++) begin
          if (w == 0 || age_rank[s][w] > best) begin
            best   = age_rank[s][w];
            chosen = w;
          end
        end
        evict_count++;
      end
      touch_way(s, chosen, !have_invalid);
      tag_mem[s][chosen]   = tag;
      valid_mem[s][chosen] = 1'b1;
      miss_count++;
    end
    r.hit = found;
    r.way = chosen[WAY_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          tag_mem[s][w]   = '0;
          valid_mem[s][w] = 1'b0;
          age_rank[s][w]  = 0;
        end
      end
      lookup_q.delete();
      fail_count  = 0;
      pending     = 0;
      hit_count   = 0;
      miss_count  = 0;
      evict_count = 0;
    end else begin
      // The result is matched before the new address is predicted, so a
      // transfer on the output never pairs with an access of the same edge.
      if (out_valid && !out_stall) begin
        if (lookup_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with no access outstanding: hit=%0b way_used=%0d",
                   $time, hit, way_used);
        end else begin
          oldest = lookup_q.pop_front();
          if (hit !== oldest.hit) begin
            fail_count++;
            $display("%0t: hit mismatch: expected %0b, actual %0b",
                     $time, oldest.hit, hit);
          end
          if (way_used !== oldest.way) begin
            fail_count++;
            $display("%0t: way_used mismatch: expected %0d, actual %0d",
                     $time, oldest.way, way_used);
          end
        end
      end
      if (in_valid && !in_stall)
        lookup_q.push_back(lookup_and_fill(address));
      pending = lookup_q.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the set-associative LRU tag store. A short
// directed sequence fills and evicts a set in a known order and touches the
// extreme addresses; random accesses then work a small pool of tags over a
// few busy sets so that hits and evictions are frequent. Both channels idle
// in random bursts, apart from quiet stretches and the end of the run.
// ----------------------------------------------------------------------------
module tb_top;
  import sacl_pkg::*;

  localparam int WAYS         = DEF_WAYS;
  localparam int SETS         = DEF_SETS;
  localparam int LINE_BYTES   = DEF_LINE_BYTES;
  localparam int OFF_W        = $clog2(LINE_BYTES);
  localparam int SET_W        = $clog2(SETS);
  localparam int TAG_POOL     = 12;
  localparam int RANDOM_ITEMS = 1600;
  localparam int QUIET_TAIL   = 200;
  localparam int CYCLE_LIMIT  = 500000;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [ADDR_W-1:0]    address;
  logic                 out_valid;
  logic                 out_stall;
  logic                 hit;
  logic [WAY_OUT_W-1:0] way_used;

  int fail_count;
  int pending;
  int hit_count;
  int miss_count;
  int evict_count;
  int cycle_count = 0;
  bit idle_on     = 1'b1;

  logic [ADDR_W-1:0] tag_pool [TAG_POOL];

  set_assoc_cache_lru_tags_top #(
    .WAYS       (WAYS),
    .SETS       (SETS),
    .LINE_BYTES (LINE_BYTES)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .address   (address),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .way_used  (way_used)
  );

  lru_tag_checker #(
    .WAYS       (WAYS),
    .SETS       (SETS),
    .LINE_BYTES (LINE_BYTES)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .address     (address),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .way_used    (way_used),
    .fail_count  (fail_count),
    .pending     (pending),
    .hit_count   (hit_count),
    .miss_count  (miss_count),
    .evict_count (evict_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[set_assoc_cache_lru_tags_top] ERROR");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] line_addr(logic [ADDR_W-1:0] tag,
                                                  int unsigned s, int unsigned off);
    return (tag << (OFF_W + SET_W)) | (ADDR_W'(s % SETS) << OFF_W) |
           ADDR_W'(off % LINE_BYTES);
  endfunction

  // Mostly a few busy sets and a tag pool larger than the ways, so that lines are
  // hit, aged and evicted; some use pool tags in any set, the rest are fully random addresses.
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned sel;
    int unsigned s;
    sel = $urandom_range(0, 99);
    if (sel < 15)
      return {$urandom, $urandom};
    s = (sel < 75) ? $urandom_range(0, 3) : $urandom_range(0, SETS - 1);
    return line_addr(tag_pool[$urandom_range(0, TAG_POOL - 1)], s, $urandom);
  endfunction

  task automatic send(input logic [ADDR_W-1:0] a);
    @(negedge clk);
    in_valid <= 1'b1;
    address  <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // The receiver alternates stall bursts with free-running stretches.
  initial begin
    int unsigned stall_len;
    out_stall = 1'b0;
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        stall_len = $urandom_range(1, 11);
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (stall_len - 1) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
    end
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    address  = '0;
    for (int i = 0; i < TAG_POOL; i++)
      tag_pool[i] = (i < TAG_POOL / 2) ? ADDR_W'($urandom_range(0, 15))
                                       : {$urandom, $urandom} >> (OFF_W + SET_W);
    tag_pool[0] = '0;
    tag_pool[1] = {ADDR_W{1'b1}} >> (OFF_W + SET_W);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Lowest and highest addresses, each followed by a hit at another offset.
    send('0);
    send(line_addr('0, 0, LINE_BYTES - 1));
    send({ADDR_W{1'b1}});
    send({ADDR_W{1'b1}} & ~ADDR_W'(LINE_BYTES - 1));
    // Fill one set in order, then refresh its oldest line and force evictions.
    for (int t = 1; t <= WAYS; t++)
      send(line_addr(ADDR_W'(t), 5, 0));
    send(line_addr(1, 5, 3));
    send(line_addr(ADDR_W'(WAYS + 1), 5, 0));
    send(line_addr(3, 5, 0));
    send(line_addr(ADDR_W'(WAYS + 2), 5, 0));
    send(line_addr(2, 5, 0));
    // Same tags in other sets must not alias.
    send(line_addr(tag_pool[1], 0, 0));
    send(line_addr('0, SETS - 1, LINE_BYTES - 1));
    send(64'h8000_0000_0000_0000);
    send(64'h8000_0000_0000_0000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = (n < RANDOM_ITEMS - QUIET_TAIL) && ((n / 200) % 3 != 2);
      if (idle_on && $urandom_range(0, 3) == 0)
        pause_sender($urandom_range(1, 11));
      send(pick_address());
    end
    idle_on = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Ran %0d accesses: %0d hits, %0d misses, %0d of them evicting a valid line.",
             hit_count + miss_count, hit_count, miss_count, evict_count);
    $display("Directed fill and eviction of one set, extreme addresses, random bursts.");
    if (fail_count == 0)
      $display("[set_assoc_cache_lru_tags_top] OK");
    else
      $display("[set_assoc_cache_lru_tags_top] ERROR");
    $finish;
  end

endmodule
